/* hw/rtl/psa_pkg.sv */
package psa_pkg;

  // Input opcodes.
  localparam logic [2:0] OP_ARRIVE = 3'd0;
  localparam logic [2:0] OP_JOIN   = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_EVICT  = 3'd3;
  localparam logic [2:0] OP_LOST   = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_ASSIGN   = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_EVICT    = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_LOST     = 3'd4;
  localparam logic [2:0] KIND_REJECT   = 3'd5;

  // Configuration register indexes.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_AGING = 1'b1;

  // Scheduling modes.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SCAN_W,
    CMD_SCAN_R,
    CMD_EXEC,
    CMD_AGE,
    CMD_SCHED,
    CMD_REINS,
    CMD_FIN
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic w_last;
    logic r_last;
    logic go_sched;
    logic go_age;
    logic go_reins;
  } sts_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] job;
    logic [7:0]  wk;
    logic [15:0] pc;
  } res_t;

endpackage

/* hw/rtl/psa_ctrl.sv */
module psa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  psa_pkg::sts_t sts_i,
  output psa_pkg::cmd_e cmd_o,
  output logic          busy
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SW1   = 10'b0000000010,
    S_SR1   = 10'b0000000100,
    S_EXEC  = 10'b0000001000,
    S_AGE   = 10'b0000010000,
    S_SR2   = 10'b0000100000,
    S_SW2   = 10'b0001000000,
    S_SCHED = 10'b0010000000,
    S_REINS = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   reins_q, reins_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    reins_d = reins_q;
    cmd_o   = psa_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = psa_pkg::CMD_LATCH;
          state_d = S_SW1;
        end
      end
      S_SW1: begin
        cmd_o = psa_pkg::CMD_SCAN_W;
        if (sts_i.w_last) state_d = S_SR1;
      end
      S_SR1: begin
        cmd_o = psa_pkg::CMD_SCAN_R;
        if (sts_i.r_last) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o   = psa_pkg::CMD_EXEC;
        reins_d = sts_i.go_reins;
        if (sts_i.go_age) state_d = S_AGE;
        else if (sts_i.go_sched) state_d = S_SR2;
        else state_d = S_FIN;
      end
      S_AGE: begin
        cmd_o = psa_pkg::CMD_AGE;
        if (sts_i.r_last) state_d = S_SR2;
      end
      S_SR2: begin
        cmd_o = psa_pkg::CMD_SCAN_R;
        if (sts_i.r_last) state_d = S_SW2;
      end
      S_SW2: begin
        cmd_o = psa_pkg::CMD_SCAN_W;
        if (sts_i.w_last) state_d = S_SCHED;
      end
      S_SCHED: begin
        cmd_o   = psa_pkg::CMD_SCHED;
        state_d = reins_q ? S_REINS : S_FIN;
      end
      S_REINS: begin
        cmd_o   = psa_pkg::CMD_REINS;
        reins_d = 1'b0;
        state_d = S_SR2;
      end
      S_FIN: begin
        cmd_o   = psa_pkg::CMD_FIN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      reins_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reins_q <= reins_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* hw/rtl/psa_dp.sv */
module psa_dp #(
  parameter int RD = 16,
  parameter int WS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic [2:0]    opcode_i,
  input  logic [7:0]    job_priority_i,
  input  logic [7:0]    worker_ident_i,
  input  logic [15:0]   saved_pc_i,
  input  psa_pkg::cmd_e cmd_i,
  output psa_pkg::sts_t sts_o,
  output logic          result_valid_o,
  output logic [2:0]    kind_o,
  output logic [15:0]   job_id_o,
  output logic [7:0]    target_worker_o,
  output logic [15:0]   resume_pc_o,
  output logic          last_o
);

  localparam int RIW = (RD > 1) ? $clog2(RD) : 1;
  localparam int WIW = (WS > 1) ? $clog2(WS) : 1;

  // Configuration.
  logic        mode_q;
  logic [15:0] period_q;

  // Ready table.
  logic [RD-1:0] rv_q;
  logic [15:0]   rjob_q   [RD];
  logic [7:0]    rprio_q  [RD];
  logic [15:0]   rpc_q    [RD];
  logic [15:0]   rstamp_q [RD];

  // Worker table.
  logic [WS-1:0] wp_q, wb_q;
  logic [7:0]    wname_q  [WS];
  logic [15:0]   wjob_q   [WS];
  logic [7:0]    wprio_q  [WS];
  logic [15:0]   wstamp_q [WS];

  // Global state.
  logic           ep_q;
  logic [WIW-1:0] eslot_q;
  logic [15:0]    nid_q, oc_q, ac_q;

  // Latched input transaction.
  logic [2:0]  op_q;
  logic [7:0]  pin_q, ident_q;
  logic [15:0] spc_q;

  // Scan counters.
  logic [WIW-1:0] w_cnt_q;
  logic [RIW-1:0] r_cnt_q;

  // Worker scan results: name match, first free slot, longest idle, worst busy.
  logic           m_v_q, m_busy_q;
  logic [WIW-1:0] m_idx_q;
  logic [15:0]    m_job_q;
  logic [7:0]     m_prio_q;
  logic           f_v_q;
  logic [WIW-1:0] f_idx_q;
  logic           i_v_q;
  logic [WIW-1:0] i_idx_q;
  logic [15:0]    i_age_q;
  logic [7:0]     i_name_q;
  logic           k_v_q;
  logic [WIW-1:0] k_idx_q;
  logic [7:0]     k_prio_q, k_name_q;
  logic [15:0]    k_job_q;

  // Ready scan results: first free entry, best entry.
  logic           rf_v_q;
  logic [RIW-1:0] rf_idx_q;
  logic           b_v_q;
  logic [RIW-1:0] b_idx_q;
  logic [7:0]     b_prio_q;
  logic [15:0]    b_age_q, b_job_q, b_pc_q;

  // Job held across a schedule when the table was full on return.
  logic [15:0] hold_job_q;
  logic [7:0]  hold_prio_q;
  logic        disp_q;

  // Result staging.
  logic [1:0]    cnt_q;
  logic          pend_v_q;
  psa_pkg::res_t pend_q;
  logic          out_v_q, out_last_q;
  psa_pkg::res_t out_q;

  // Scan comparisons for the current entries.
  logic        w_first, r_first;
  logic [15:0] w_age, r_age;
  logic        m_hit, f_hit, i_hit, k_hit, rf_hit, b_hit;
  logic        m_base, f_base, i_base, k_base, rf_base, b_base;

  assign w_first = (w_cnt_q == '0);
  assign r_first = (r_cnt_q == '0);
  assign w_age   = oc_q - wstamp_q[w_cnt_q];
  assign r_age   = oc_q - rstamp_q[r_cnt_q];
  assign m_base  = !w_first && m_v_q;
  assign f_base  = !w_first && f_v_q;
  assign i_base  = !w_first && i_v_q;
  assign k_base  = !w_first && k_v_q;
  assign rf_base = !r_first && rf_v_q;
  assign b_base  = !r_first && b_v_q;

  always_comb begin
    m_hit  = wp_q[w_cnt_q] && (wname_q[w_cnt_q] == ident_q) && !m_base;
    f_hit  = !wp_q[w_cnt_q] && !f_base;
    i_hit  = wp_q[w_cnt_q] && !wb_q[w_cnt_q] && (!i_base || (w_age > i_age_q));
    k_hit  = wp_q[w_cnt_q] && wb_q[w_cnt_q] && (!k_base || (wprio_q[w_cnt_q] > k_prio_q));
    rf_hit = !rv_q[r_cnt_q] && !rf_base;
    if (mode_q == psa_pkg::MODE_PRIO) begin
      b_hit = rv_q[r_cnt_q] && (!b_base || (rprio_q[r_cnt_q] < b_prio_q) ||
              ((rprio_q[r_cnt_q] == b_prio_q) && (r_age > b_age_q)));
    end else begin
      b_hit = rv_q[r_cnt_q] && (!b_base || (r_age > b_age_q));
    end
  end

  // Event execution and scheduling decisions.
  logic           ok, ins;
  logic [RIW-1:0] ins_idx;
  logic [15:0]    ins_job, ins_pc, ins_stamp;
  logic [7:0]     ins_prio;
  logic           w_join, w_free, w_lost, w_disp, ep_clr, ep_set, r_clr;
  logic           oc_inc1, oc_inc2, nid_inc, hold_ld, ac_ld;
  logic [15:0]    ac_d, ac_inc, nid_inc_v;
  logic           emit_v, disp_now;
  logic           go_sched, go_age, go_reins;
  psa_pkg::res_t  emit_r;

  assign ac_inc    = ac_q + 16'd1;
  assign nid_inc_v = nid_q + 16'd1;

  always_comb begin
    ok       = 1'b0;
    ins      = 1'b0;
    ins_idx  = rf_idx_q;
    ins_job  = nid_q;
    ins_prio = pin_q;
    ins_pc   = 16'd0;
    ins_stamp = oc_q;
    w_join   = 1'b0;
    w_free   = 1'b0;
    w_lost   = 1'b0;
    w_disp   = 1'b0;
    ep_clr   = 1'b0;
    ep_set   = 1'b0;
    r_clr    = 1'b0;
    oc_inc1  = 1'b0;
    oc_inc2  = 1'b0;
    nid_inc  = 1'b0;
    hold_ld  = 1'b0;
    ac_ld    = 1'b0;
    ac_d     = ac_q;
    emit_v   = 1'b0;
    emit_r   = '{kind: psa_pkg::KIND_REJECT, job: 16'd0, wk: ident_q, pc: 16'd0};
    disp_now = 1'b0;
    go_sched = 1'b0;
    go_age   = 1'b0;
    go_reins = 1'b0;
    case (cmd_i)
      psa_pkg::CMD_EXEC: begin
        case (op_q)
          psa_pkg::OP_ARRIVE: begin
            ok = rf_v_q;
            emit_v = 1'b1;
            if (ok) begin
              ins     = 1'b1;
              nid_inc = 1'b1;
              oc_inc1 = 1'b1;
              emit_r  = '{kind: psa_pkg::KIND_ASSIGN, job: nid_q, wk: 8'd0, pc: 16'd0};
            end else begin
              emit_r.wk = 8'd0;
            end
            go_sched = ok;
          end
          psa_pkg::OP_JOIN: begin
            ok = !m_v_q && f_v_q;
            if (ok) begin
              w_join  = 1'b1;
              oc_inc1 = 1'b1;
            end else begin
              emit_v = 1'b1;
            end
            go_sched = ok;
          end
          psa_pkg::OP_FINISH: begin
            ok = m_v_q && m_busy_q;
            emit_v = 1'b1;
            if (ok) begin
              emit_r  = '{kind: psa_pkg::KIND_DONE, job: m_job_q, wk: ident_q, pc: 16'd0};
              ep_clr  = ep_q && (eslot_q == m_idx_q);
              w_free  = 1'b1;
              oc_inc1 = 1'b1;
            end
            go_sched = ok;
          end
          psa_pkg::OP_EVICT: begin
            ok = m_v_q && m_busy_q && ep_q && (eslot_q == m_idx_q);
            if (ok) begin
              w_free  = 1'b1;
              ep_clr  = 1'b1;
              hold_ld = 1'b1;
              if (rf_v_q) begin
                // The worker takes the current stamp, the job the next one.
                ins       = 1'b1;
                ins_job   = m_job_q;
                ins_prio  = m_prio_q;
                ins_pc    = spc_q;
                ins_stamp = oc_q + 16'd1;
                oc_inc2   = 1'b1;
              end else begin
                oc_inc1  = 1'b1;
                go_reins = 1'b1;
              end
            end else begin
              emit_v = 1'b1;
            end
            go_sched = ok;
          end
          psa_pkg::OP_LOST: begin
            ok = m_v_q;
            if (ok) begin
              emit_v = m_busy_q;
              emit_r = '{kind: psa_pkg::KIND_LOST, job: m_job_q, wk: ident_q, pc: 16'd0};
              ep_clr = ep_q && (eslot_q == m_idx_q);
              w_lost = 1'b1;
            end else begin
              emit_v = 1'b1;
            end
            go_sched = ok;
          end
          psa_pkg::OP_TICK: begin
            ac_ld = 1'b1;
            if ((mode_q == psa_pkg::MODE_PRIO) && (period_q != 16'd0)) begin
              if (ac_inc >= period_q) begin
                ac_d   = 16'd0;
                go_age = 1'b1;
              end else begin
                ac_d = ac_inc;
              end
            end else begin
              ac_d = 16'd0;
            end
            go_sched = 1'b1;
          end
          default: begin
          end
        endcase
      end
      psa_pkg::CMD_SCHED: begin
        if (b_v_q) begin
          if (i_v_q) begin
            disp_now = 1'b1;
            w_disp   = 1'b1;
            r_clr    = 1'b1;
            emit_v   = 1'b1;
            emit_r   = '{kind: psa_pkg::KIND_DISPATCH, job: b_job_q, wk: i_name_q,
                         pc: b_pc_q};
          end else if ((mode_q == psa_pkg::MODE_PRIO) && !ep_q && k_v_q &&
                       (b_prio_q < k_prio_q)) begin
            ep_set = 1'b1;
            emit_v = 1'b1;
            emit_r = '{kind: psa_pkg::KIND_EVICT, job: k_job_q, wk: k_name_q, pc: 16'd0};
          end
        end
      end
      psa_pkg::CMD_REINS: begin
        if (disp_q) begin
          // The dispatched entry is the one just freed.
          ins      = 1'b1;
          ins_idx  = b_idx_q;
          ins_job  = hold_job_q;
          ins_prio = hold_prio_q;
          ins_pc   = spc_q;
          oc_inc1  = 1'b1;
        end else begin
          emit_v = 1'b1;
          emit_r = '{kind: psa_pkg::KIND_LOST, job: hold_job_q, wk: ident_q, pc: 16'd0};
        end
      end
      default: begin
      end
    endcase
  end

  // Status towards the controller.
  assign sts_o = '{w_last:   (w_cnt_q == WIW'(WS - 1)),
                   r_last:   (r_cnt_q == RIW'(RD - 1)),
                   go_sched: go_sched,
                   go_age:   go_age,
                   go_reins: go_reins};

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= psa_pkg::MODE_FIFO;
      period_q <= 16'd0;
      rv_q     <= '0;
      wp_q     <= '0;
      wb_q     <= '0;
      ep_q     <= 1'b0;
      nid_q    <= 16'd1;
      oc_q     <= 16'd0;
      ac_q     <= 16'd0;
      w_cnt_q  <= '0;
      r_cnt_q  <= '0;
      disp_q   <= 1'b0;
      cnt_q    <= 2'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == psa_pkg::REG_MODE) mode_q <= cfg_data_i[0];
        else period_q <= cfg_data_i;
      end
      // Scan counters wrap to zero after the last entry.
      if (cmd_i == psa_pkg::CMD_SCAN_W) begin
        w_cnt_q <= sts_o.w_last ? '0 : w_cnt_q + WIW'(1);
      end
      if ((cmd_i == psa_pkg::CMD_SCAN_R) || (cmd_i == psa_pkg::CMD_AGE)) begin
        r_cnt_q <= sts_o.r_last ? '0 : r_cnt_q + RIW'(1);
      end
      if (ins) rv_q[ins_idx] <= 1'b1;
      if (r_clr) rv_q[b_idx_q] <= 1'b0;
      if (w_join) begin
        wp_q[f_idx_q] <= 1'b1;
        wb_q[f_idx_q] <= 1'b0;
      end
      if (w_free) wb_q[m_idx_q] <= 1'b0;
      if (w_lost) begin
        wp_q[m_idx_q] <= 1'b0;
        wb_q[m_idx_q] <= 1'b0;
      end
      if (w_disp) wb_q[i_idx_q] <= 1'b1;
      if (ep_clr) ep_q <= 1'b0;
      if (ep_set) ep_q <= 1'b1;
      if (nid_inc) nid_q <= (nid_inc_v == 16'd0) ? 16'd1 : nid_inc_v;
      if (oc_inc1) oc_q <= oc_q + 16'd1;
      if (oc_inc2) oc_q <= oc_q + 16'd2;
      if (ac_ld) ac_q <= ac_d;
      if (cmd_i == psa_pkg::CMD_SCHED) disp_q <= disp_now;
      // Result staging: a result is held until the next one or the end of the event.
      out_v_q <= 1'b0;
      if (cmd_i == psa_pkg::CMD_LATCH) cnt_q <= 2'd0;
      if (emit_v && (cnt_q != 2'd2)) begin
        cnt_q    <= cnt_q + 2'd1;
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end
      if ((cmd_i == psa_pkg::CMD_FIN) && pend_v_q) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i == psa_pkg::CMD_LATCH) begin
      op_q    <= opcode_i;
      pin_q   <= job_priority_i;
      ident_q <= worker_ident_i;
      spc_q   <= saved_pc_i;
    end
    if (cmd_i == psa_pkg::CMD_SCAN_W) begin
      if (w_first) begin
        m_v_q <= 1'b0;
        f_v_q <= 1'b0;
        i_v_q <= 1'b0;
        k_v_q <= 1'b0;
      end
      if (m_hit) begin
        m_v_q    <= 1'b1;
        m_idx_q  <= w_cnt_q;
        m_busy_q <= wb_q[w_cnt_q];
        m_job_q  <= wjob_q[w_cnt_q];
        m_prio_q <= wprio_q[w_cnt_q];
      end
      if (f_hit) begin
        f_v_q   <= 1'b1;
        f_idx_q <= w_cnt_q;
      end
      if (i_hit) begin
        i_v_q    <= 1'b1;
        i_idx_q  <= w_cnt_q;
        i_age_q  <= w_age;
        i_name_q <= wname_q[w_cnt_q];
      end
      if (k_hit) begin
        k_v_q    <= 1'b1;
        k_idx_q  <= w_cnt_q;
        k_prio_q <= wprio_q[w_cnt_q];
        k_job_q  <= wjob_q[w_cnt_q];
        k_name_q <= wname_q[w_cnt_q];
      end
    end
    if (cmd_i == psa_pkg::CMD_SCAN_R) begin
      if (r_first) begin
        rf_v_q <= 1'b0;
        b_v_q  <= 1'b0;
      end
      if (rf_hit) begin
        rf_v_q   <= 1'b1;
        rf_idx_q <= r_cnt_q;
      end
      if (b_hit) begin
        b_v_q    <= 1'b1;
        b_idx_q  <= r_cnt_q;
        b_prio_q <= rprio_q[r_cnt_q];
        b_age_q  <= r_age;
        b_job_q  <= rjob_q[r_cnt_q];
        b_pc_q   <= rpc_q[r_cnt_q];
      end
    end
    // Aging pass, one entry a cycle.
    if ((cmd_i == psa_pkg::CMD_AGE) && rv_q[r_cnt_q] && (rprio_q[r_cnt_q] != 8'd0)) begin
      rprio_q[r_cnt_q] <= rprio_q[r_cnt_q] - 8'd1;
    end
    if (ins) begin
      rjob_q[ins_idx]   <= ins_job;
      rprio_q[ins_idx]  <= ins_prio;
      rpc_q[ins_idx]    <= ins_pc;
      rstamp_q[ins_idx] <= ins_stamp;
    end
    if (w_join) begin
      wname_q[f_idx_q]  <= ident_q;
      wstamp_q[f_idx_q] <= oc_q;
    end
    if (w_free) wstamp_q[m_idx_q] <= oc_q;
    if (w_disp) begin
      wjob_q[i_idx_q]  <= b_job_q;
      wprio_q[i_idx_q] <= b_prio_q;
    end
    if (ep_set) eslot_q <= k_idx_q;
    if (hold_ld) begin
      hold_job_q  <= m_job_q;
      hold_prio_q <= m_prio_q;
    end
    if (emit_v && (cnt_q != 2'd2)) begin
      pend_q <= emit_r;
      if (pend_v_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b0;
      end
    end
    if ((cmd_i == psa_pkg::CMD_FIN) && pend_v_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign result_valid_o  = out_v_q;
  assign kind_o          = out_q.kind;
  assign job_id_o        = out_q.job;
  assign target_worker_o = out_q.wk;
  assign resume_pc_o     = out_q.pc;
  assign last_o          = out_last_q;

endmodule

/* hw/rtl/priority_scheduler_with_aging.sv */
// Priority scheduler with aging for jobs and workers.
//
// An event transaction is taken at a rising edge with start high and busy low;
// opcode_i selects job arrival, worker join, job finish, eviction return, worker
// loss or a tick, with job_priority_i, worker_ident_i and saved_pc_i as operands.
// Results appear on kind_o, job_id_o, target_worker_o and resume_pc_o for one
// cycle each, flagged by result_valid_o; last_o marks the final one of an event.
// The final result is shown in the first cycle after busy falls, and a new event
// can be taken at the edge that ends that cycle.
// The receiver cannot stall, so each result is taken in the cycle it is shown.
// The worker and ready tables are scanned one entry a cycle, once before the
// event is applied and once for the scheduling decision. Events that end
// without scheduling (rejects and unused codes) skip the second scan. An aging
// pass adds a pass over the ready table, and a return into a full table adds
// one more ready and worker scan. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while idle; the user must keep to this, as the
// block itself does not enforce it. After reset all tables are empty, the mode
// is first come first served, aging is off and the first job id is one.
module priority_scheduler_with_aging #(
  parameter int READY_DEPTH  = 16,
  parameter int WORKER_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  job_priority_i,
  input  logic [7:0]  worker_ident_i,
  input  logic [15:0] saved_pc_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [15:0] job_id_o,
  output logic [7:0]  target_worker_o,
  output logic [15:0] resume_pc_o,
  output logic        last_o
);

  psa_pkg::cmd_e cmd;
  psa_pkg::sts_t sts;

  // Sequencer.
  psa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Tables, scans and result staging.
  psa_dp #(
    .RD (READY_DEPTH),
    .WS (WORKER_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .job_priority_i  (job_priority_i),
    .worker_ident_i  (worker_ident_i),
    .saved_pc_i      (saved_pc_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .job_id_o        (job_id_o),
    .target_worker_o (target_worker_o),
    .resume_pc_o     (resume_pc_o),
    .last_o          (last_o)
  );

endmodule

/* hw/rtl/psa_checker.sv */
module psa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [2:0]  kind_o,
  input logic [15:0] job_id_o,
  input logic        last_o
);

  // An accepted event transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("event accepted but block not busy");

  // A result that is not the last of its event is issued while still busy.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy) else $error("non-final result while idle");

  // Result kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> kind_o <= psa_pkg::KIND_REJECT) else $error("bad result kind");

  // An assigned id is never zero.
  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == psa_pkg::KIND_ASSIGN) |-> job_id_o != 16'd0)
    else $error("zero job id assigned");

endmodule

bind priority_scheduler_with_aging psa_checker u_psa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .job_id_o       (job_id_o),
  .last_o         (last_o)
);

/* tb/tb_priority_scheduler_with_aging.sv */
`timescale 1ns / 100ps

module tb_priority_scheduler_with_aging;

  localparam int RDEPTH = 16;
  localparam int WSLOTS = 8;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    psa_pkg::res_t r;
    logic last;
  } sched_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  prio;
    logic [7:0]  ident;
    logic [15:0] pc;
    bit          chk;
    logic [2:0]  kind;
  } event_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i = '0;
  logic [7:0]  job_priority_i = '0;
  logic [7:0]  worker_ident_i = '0;
  logic [15:0] saved_pc_i = '0;
  logic        result_valid_o;
  logic [2:0]  kind_o;
  logic [15:0] job_id_o;
  logic [7:0]  target_worker_o;
  logic [15:0] resume_pc_o;
  logic        last_o;

  int err_cnt = 0;

  priority_scheduler_with_aging i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Scheduler state mirrored by the predictor.
  logic        mode_q;
  logic [15:0] aging_period_q;
  bit          rdy_v [RDEPTH];
  logic [15:0] rdy_job [RDEPTH];
  logic [7:0]  rdy_prio [RDEPTH];
  logic [15:0] rdy_pc [RDEPTH];
  logic [15:0] rdy_stamp [RDEPTH];
  bit          wk_present [WSLOTS];
  bit          wk_busy [WSLOTS];
  logic [7:0]  wk_name [WSLOTS];
  logic [15:0] wk_job [WSLOTS];
  logic [7:0]  wk_prio [WSLOTS];
  logic [15:0] wk_stamp [WSLOTS];
  bit          evict_pend;
  int          evict_slot;
  logic [15:0] next_id;
  logic [15:0] order_cnt;
  logic [15:0] aging_cnt;

  psa_pkg::res_t event_res_q[$];
  sched_res_t    pending_res_q[$];

  function automatic void sched_reset();
    mode_q = psa_pkg::MODE_FIFO;
    aging_period_q = '0;
    foreach (rdy_v[i]) rdy_v[i] = 1'b0;
    foreach (wk_present[i]) begin
      wk_present[i] = 1'b0;
      wk_busy[i] = 1'b0;
    end
    evict_pend = 1'b0;
    evict_slot = 0;
    next_id = 16'd1;
    order_cnt = '0;
    aging_cnt = '0;
  endfunction

  function automatic logic [15:0] take_stamp();
    logic [15:0] s;
    s = order_cnt;
    order_cnt = order_cnt + 16'd1;
    return s;
  endfunction

  function automatic logic [15:0] age_of(logic [15:0] s);
    return order_cnt - s;
  endfunction

  function automatic void add_res(logic [2:0] k, logic [15:0] j, logic [7:0] w,
                                  logic [15:0] p);
    psa_pkg::res_t r;
    r.kind = k;
    r.job = j;
    r.wk = w;
    r.pc = p;
    if (event_res_q.size() < 2) event_res_q.push_back(r);
  endfunction

  function automatic int best_ready();
    int b;
    b = -1;
    for (int i = 0; i < RDEPTH; i++) begin
      if (!rdy_v[i]) continue;
      if (b < 0) b = i;
      else if (mode_q == psa_pkg::MODE_PRIO) begin
        if (rdy_prio[i] < rdy_prio[b] ||
            (rdy_prio[i] == rdy_prio[b] && age_of(rdy_stamp[i]) > age_of(rdy_stamp[b])))
          b = i;
      end else if (age_of(rdy_stamp[i]) > age_of(rdy_stamp[b])) b = i;
    end
    return b;
  endfunction

  function automatic int longest_idle();
    int b;
    b = -1;
    for (int i = 0; i < WSLOTS; i++) begin
      if (!wk_present[i] || wk_busy[i]) continue;
      if (b < 0 || age_of(wk_stamp[i]) > age_of(wk_stamp[b])) b = i;
    end
    return b;
  endfunction

  function automatic int find_worker(logic [7:0] name);
    for (int i = 0; i < WSLOTS; i++)
      if (wk_present[i] && wk_name[i] == name) return i;
    return -1;
  endfunction

  function automatic int free_ready();
    for (int i = 0; i < RDEPTH; i++)
      if (!rdy_v[i]) return i;
    return -1;
  endfunction

  function automatic void insert_ready(int s, logic [15:0] j, logic [7:0] p, logic [15:0] pc);
    rdy_v[s] = 1'b1;
    rdy_job[s] = j;
    rdy_prio[s] = p;
    rdy_pc[s] = pc;
    rdy_stamp[s] = take_stamp();
  endfunction

  // Dispatch the best ready job, or in priority mode ask the worst running job to yield.
  function automatic void dispatch_or_preempt();
    int r, w, worst;
    r = best_ready();
    if (r < 0) return;
    w = longest_idle();
    if (w >= 0) begin
      wk_busy[w] = 1'b1;
      wk_job[w] = rdy_job[r];
      wk_prio[w] = rdy_prio[r];
      rdy_v[r] = 1'b0;
      add_res(psa_pkg::KIND_DISPATCH, rdy_job[r], wk_name[w], rdy_pc[r]);
      return;
    end
    if (mode_q == psa_pkg::MODE_PRIO && !evict_pend) begin
      worst = -1;
      for (int i = 0; i < WSLOTS; i++) begin
        if (!wk_present[i] || !wk_busy[i]) continue;
        if (worst < 0 || wk_prio[i] > wk_prio[worst]) worst = i;
      end
      if (worst >= 0 && rdy_prio[r] < wk_prio[worst]) begin
        evict_pend = 1'b1;
        evict_slot = worst;
        add_res(psa_pkg::KIND_EVICT, wk_job[worst], wk_name[worst], '0);
      end
    end
  endfunction

  // Apply one accepted event and queue the results it should produce.
  function automatic void predict_event(logic [2:0] op, logic [7:0] prio, logic [7:0] ident,
                                        logic [15:0] spc);
    int w, s;
    logic [15:0] j;
    logic [7:0] jp;
    sched_res_t e;
    event_res_q.delete();
    case (op)
      psa_pkg::OP_ARRIVE: begin
        s = free_ready();
        if (s < 0) add_res(psa_pkg::KIND_REJECT, '0, '0, '0);
        else begin
          j = next_id;
          next_id = next_id + 16'd1;
          if (next_id == '0) next_id = 16'd1;
          insert_ready(s, j, prio, '0);
          add_res(psa_pkg::KIND_ASSIGN, j, '0, '0);
          dispatch_or_preempt();
        end
      end
      psa_pkg::OP_JOIN: begin
        w = -1;
        if (find_worker(ident) < 0)
          for (int i = 0; i < WSLOTS; i++)
            if (!wk_present[i]) begin
              w = i;
              break;
            end
        if (w < 0) add_res(psa_pkg::KIND_REJECT, '0, ident, '0);
        else begin
          wk_present[w] = 1'b1;
          wk_busy[w] = 1'b0;
          wk_name[w] = ident;
          wk_stamp[w] = take_stamp();
          dispatch_or_preempt();
        end
      end
      psa_pkg::OP_FINISH: begin
        w = find_worker(ident);
        if (w < 0 || !wk_busy[w]) add_res(psa_pkg::KIND_REJECT, '0, ident, '0);
        else begin
          add_res(psa_pkg::KIND_DONE, wk_job[w], ident, '0);
          if (evict_pend && evict_slot == w) evict_pend = 1'b0;
          wk_busy[w] = 1'b0;
          wk_stamp[w] = take_stamp();
          dispatch_or_preempt();
        end
      end
      psa_pkg::OP_EVICT: begin
        w = find_worker(ident);
        if (w < 0 || !wk_busy[w] || !evict_pend || evict_slot != w)
          add_res(psa_pkg::KIND_REJECT, '0, ident, '0);
        else begin
          j = wk_job[w];
          jp = wk_prio[w];
          wk_busy[w] = 1'b0;
          wk_stamp[w] = take_stamp();
          evict_pend = 1'b0;
          s = free_ready();
          if (s < 0) begin
            dispatch_or_preempt();
            s = free_ready();
          end
          if (s >= 0) insert_ready(s, j, jp, spc);
          else add_res(psa_pkg::KIND_LOST, j, ident, '0);
          dispatch_or_preempt();
        end
      end
      psa_pkg::OP_LOST: begin
        w = find_worker(ident);
        if (w < 0) add_res(psa_pkg::KIND_REJECT, '0, ident, '0);
        else begin
          if (wk_busy[w]) add_res(psa_pkg::KIND_LOST, wk_job[w], ident, '0);
          if (evict_pend && evict_slot == w) evict_pend = 1'b0;
          wk_present[w] = 1'b0;
          wk_busy[w] = 1'b0;
          dispatch_or_preempt();
        end
      end
      psa_pkg::OP_TICK: begin
        if (mode_q == psa_pkg::MODE_PRIO && aging_period_q != '0) begin
          aging_cnt = aging_cnt + 16'd1;
          if (aging_cnt >= aging_period_q) begin
            aging_cnt = '0;
            for (int i = 0; i < RDEPTH; i++)
              if (rdy_v[i] && rdy_prio[i] > 0) rdy_prio[i] = rdy_prio[i] - 8'd1;
          end
        end else aging_cnt = '0;
        dispatch_or_preempt();
      end
      default: ;
    endcase
    foreach (event_res_q[i]) begin
      e.r = event_res_q[i];
      e.last = (i == event_res_q.size() - 1);
      pending_res_q.push_back(e);
    end
  endfunction

  // Compare every result transaction with the oldest expectation.
  always @(negedge clk_i) begin
    sched_res_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_res_q.size() == 0) begin
        $error("unexpected result: kind %0d job %0d", kind_o, job_id_o);
        err_cnt++;
      end else begin
        e = pending_res_q.pop_front();
        if (kind_o !== e.r.kind) begin
          $error("kind: expected %0d, got %0d", e.r.kind, kind_o);
          err_cnt++;
        end
        if (job_id_o !== e.r.job) begin
          $error("job_id: expected %0d, got %0d", e.r.job, job_id_o);
          err_cnt++;
        end
        if (target_worker_o !== e.r.wk) begin
          $error("target_worker: expected %0d, got %0d", e.r.wk, target_worker_o);
          err_cnt++;
        end
        if (resume_pc_o !== e.r.pc) begin
          $error("resume_pc: expected %0d, got %0d", e.r.pc, resume_pc_o);
          err_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // Present one event from a rising edge and hold it until accepted.
  task automatic send_event(logic [2:0] op, logic [7:0] prio, logic [7:0] ident,
                            logic [15:0] pc);
    start <= 1'b1;
    opcode_i <= op;
    job_priority_i <= prio;
    worker_ident_i <= ident;
    saved_pc_i <= pc;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    predict_event(op, prio, ident, pc);
  endtask

  // Let the block drain, then write one register.
  task automatic write_reg(logic idx, logic [15:0] val);
    start <= 1'b0;
    do @(negedge clk_i); while (busy || pending_res_q.size() != 0);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == psa_pkg::REG_MODE) mode_q = val[0];
    else aging_period_q = val;
  endtask

  // Name of a worker matching the wanted condition, or -1 when there is none.
  function automatic int some_worker(bit need_busy);
    int c[$];
    for (int i = 0; i < WSLOTS; i++)
      if (wk_present[i] && (!need_busy || wk_busy[i])) c.push_back(i);
    if (c.size() == 0) return -1;
    return wk_name[c[$urandom_range(0, c.size() - 1)]];
  endfunction

  task automatic send_random_event();
    int sel, nm;
    logic [2:0] op;
    logic [7:0] id;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
    if (sel < 25) op = psa_pkg::OP_ARRIVE;
    else if (sel < 40) op = psa_pkg::OP_JOIN;
    else if (sel < 58) begin
      op = psa_pkg::OP_FINISH;
      nm = some_worker(1'b1);
      if (nm >= 0 && $urandom_range(0, 6) != 0) id = 8'(nm);
    end else if (sel < 70) begin
      op = psa_pkg::OP_EVICT;
      if (evict_pend && $urandom_range(0, 6) != 0) id = wk_name[evict_slot];
      else begin
        nm = some_worker(1'b1);
        if (nm >= 0) id = 8'(nm);
      end
    end else if (sel < 78) begin
      op = psa_pkg::OP_LOST;
      nm = some_worker(1'b0);
      if (nm >= 0 && $urandom_range(0, 4) != 0) id = 8'(nm);
    end else if (sel < 96) op = psa_pkg::OP_TICK;
    else op = 3'($urandom_range(0, 7));
    send_event(op, 8'($urandom_range(0, 255)), id, 16'($urandom_range(0, 65535)));
  endtask

  event_row_t dir_tab [20] = '{
    '{psa_pkg::OP_ARRIVE, 8'd0,   8'd0,   16'h0000, 1'b1, psa_pkg::KIND_ASSIGN},
    '{psa_pkg::OP_FINISH, 8'd0,   8'd5,   16'h0000, 1'b1, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_EVICT,  8'd0,   8'd5,   16'hFFFF, 1'b1, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_LOST,   8'd0,   8'd9,   16'h0000, 1'b1, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd0,   16'h0000, 1'b1, psa_pkg::KIND_DISPATCH},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd0,   16'h0000, 1'b1, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_ARRIVE, 8'd255, 8'd0,   16'h0000, 1'b1, psa_pkg::KIND_ASSIGN},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd255, 16'h0000, 1'b1, psa_pkg::KIND_DISPATCH},
    '{psa_pkg::OP_FINISH, 8'd0,   8'd0,   16'h0000, 1'b1, psa_pkg::KIND_DONE},
    '{psa_pkg::OP_TICK,   8'd0,   8'd0,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{OP_SPARE6,          8'd0,   8'd0,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{OP_SPARE7,          8'd255, 8'd255, 16'hFFFF, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd1,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd2,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd3,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd4,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd5,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd6,   16'h0000, 1'b0, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_JOIN,   8'd0,   8'd7,   16'h0000, 1'b1, psa_pkg::KIND_REJECT},
    '{psa_pkg::OP_LOST,   8'd0,   8'd255, 16'h0000, 1'b1, psa_pkg::KIND_LOST}
  };

  // Settings per random phase: mode and aging period.
  logic        phase_mode [5] = '{psa_pkg::MODE_PRIO, psa_pkg::MODE_PRIO, psa_pkg::MODE_PRIO,
                                  psa_pkg::MODE_FIFO, psa_pkg::MODE_PRIO};
  logic [15:0] phase_aging [5] = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd2};

  initial begin
    sched_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events in first come first served mode.
    foreach (dir_tab[i]) begin
      send_event(dir_tab[i].op, dir_tab[i].prio, dir_tab[i].ident, dir_tab[i].pc);
      if (dir_tab[i].chk) begin
        if (event_res_q.size() == 0) begin
          $error("kind: expected %0d, got no result for directed row %0d",
                 dir_tab[i].kind, i);
          err_cnt++;
        end else if (event_res_q[0].kind != dir_tab[i].kind) begin
          $error("kind: expected %0d, got %0d for directed row %0d",
                 dir_tab[i].kind, event_res_q[0].kind, i);
          err_cnt++;
        end
      end
    end

    // Random phases over several settings; the final one runs without gaps.
    for (int p = 0; p < 5; p++) begin
      write_reg(psa_pkg::REG_MODE, {15'd0, phase_mode[p]});
      write_reg(psa_pkg::REG_AGING, phase_aging[p]);
      for (int n = 0; n < 100; n++) begin
        send_random_event();
        if (p < 4 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    do @(negedge clk_i); while (busy || pending_res_q.size() != 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
